FILE: rtl/gwp_pkg.sv
// Package for the G-code word parser: shared types and constants.
// No dependencies.
package gwp_pkg;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [2:0] {
		LT_G = 3'd0, LT_X = 3'd1, LT_Y = 3'd2, LT_Z = 3'd3,
		LT_I = 3'd4, LT_J = 3'd5, LT_K = 3'd6, LT_F = 3'd7
	} letter_t;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001, PH_LETTER = 4'b0010, PH_INT = 4'b0100, PH_FRAC = 4'b1000
	} phase_t;

	// classified character handed from front to back
	typedef struct packed {
		logic       flush;
		logic       line_end;
		logic       is_letter;
		letter_t    letter;
		logic       is_digit;
		logic [3:0] digit;
		logic       is_minus;
		logic       is_point;
	} cls_t;
endpackage

FILE: rtl/gwp_front.sv
// Front end: accepts characters, classifies them and queues them.
// Depends on gwp_pkg.
module gwp_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_char,
	input  logic             in_line_end,
	input  logic             in_flush,
	output logic             q_valid,
	input  logic             q_ready,
	output gwp_pkg::cls_t    q_item
);
	gwp_pkg::cls_t mem [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	gwp_pkg::cls_t c;
	logic push, pop;

	always_comb begin
		c = '0;
		c.flush = in_flush;
		c.line_end = in_line_end;
		c.is_letter = 1'b1;
		unique case (in_char)
			8'h47: c.letter = gwp_pkg::LT_G;
			8'h58: c.letter = gwp_pkg::LT_X;
			8'h59: c.letter = gwp_pkg::LT_Y;
			8'h5A: c.letter = gwp_pkg::LT_Z;
			8'h49: c.letter = gwp_pkg::LT_I;
			8'h4A: c.letter = gwp_pkg::LT_J;
			8'h4B: c.letter = gwp_pkg::LT_K;
			8'h46: c.letter = gwp_pkg::LT_F;
			default: begin
				c.letter = gwp_pkg::LT_G;
				c.is_letter = 1'b0;
			end
		endcase
		c.is_digit = (in_char >= gwp_pkg::CH_ZERO) && (in_char <= gwp_pkg::CH_NINE);
		c.digit = c.is_digit ? 4'(in_char - gwp_pkg::CH_ZERO) : 4'd0;
		c.is_minus = in_char == gwp_pkg::CH_MINUS;
		c.is_point = in_char == gwp_pkg::CH_POINT;
	end

	assign in_ready = cnt_q != 3'd4;
	assign q_valid = cnt_q != 3'd0;
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;
	assign q_item = mem[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end
endmodule

FILE: rtl/gwp_back.sv
// Back end: scans words, keeps modal values and emits line snapshots.
// Depends on gwp_pkg.
module gwp_back #(
	parameter int FRACTION_DIGITS = 4,
	parameter int VALUE_BITS = 40
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_ready,
	input  gwp_pkg::cls_t         q_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            motion_q,
	output logic [VALUE_BITS-1:0] val_q [7],
	output logic [6:0]            seen_q,
	output logic                  bad_q
);
	localparam int MB = VALUE_BITS + 1;
	localparam logic [MB-1:0] CAP = MB'(1) << (VALUE_BITS - 1);
	localparam logic [MB-1:0] SCALE = MB'(10 ** FRACTION_DIGITS);

	gwp_pkg::phase_t ph_q, ph;
	gwp_pkg::letter_t let_q, let_n;
	logic minus_q, minus_n;
	logic [MB-1:0] acc_q, acc_n;
	logic [2:0] fc_q, fc_n;
	logic [1:0] mot_r_q, mot_n;
	logic [VALUE_BITS-1:0] wv_q [7];
	logic [VALUE_BITS-1:0] wv_n [7];
	logic [6:0] seen_r_q, seen_n;
	logic bad_r_q, bad_n;
	logic out_valid_q;
	logic take, fin_old, redisp;
	logic [MB+4:0] sh, fa;
	logic [MB-1:0] add;
	logic [2:0] idx_old, idx_end;

	function automatic logic [MB-1:0] pow10(input logic [2:0] n);
		logic [MB-1:0] p;
		p = MB'(1);
		for (int i = 0; i < 7; i++) if (3'(i) < n) p = MB'(p * 10);
		return p;
	endfunction

	function automatic logic [VALUE_BITS-1:0] word_val(input logic neg,
		input logic [MB-1:0] mag);
		if (neg) return VALUE_BITS'(-mag);
		return (mag >= CAP) ? VALUE_BITS'(CAP - MB'(1)) : VALUE_BITS'(mag);
	endfunction

	function automatic logic g_bad(input logic neg, input logic [MB-1:0] mag);
		return (neg && mag != '0) || mag > MB'(3);
	endfunction

	assign out_valid = out_valid_q;
	assign q_ready = !out_valid_q || out_ready;
	assign take = q_valid && q_ready;

	always_comb begin
		ph = q_item.flush ? gwp_pkg::PH_IDLE : ph_q;
		let_n = let_q;
		minus_n = q_item.flush ? 1'b0 : minus_q;
		acc_n = q_item.flush ? '0 : acc_q;
		fc_n = q_item.flush ? 3'd0 : fc_q;
		mot_n = q_item.flush ? 2'd0 : mot_r_q;
		seen_n = q_item.flush ? 7'd0 : seen_r_q;
		bad_n = bad_r_q;
		for (int i = 0; i < 7; i++) wv_n[i] = q_item.flush ? '0 : wv_q[i];
		fin_old = 1'b0;
		redisp = 1'b0;
		add = (let_q == gwp_pkg::LT_G) ? MB'(q_item.digit)
			: MB'(MB'(q_item.digit) * SCALE);
		sh = (MB+5)'({acc_n, 3'b0}) + (MB+5)'({acc_n, 1'b0}) + (MB+5)'(add);
		fa = (MB+5)'(acc_n) + (MB+5)'(MB'(MB'(q_item.digit) * pow10(3'(FRACTION_DIGITS - 1) - fc_n)));
		unique case (ph) inside
			gwp_pkg::PH_IDLE: redisp = 1'b1;
			gwp_pkg::PH_LETTER, gwp_pkg::PH_INT: begin
				if (ph == gwp_pkg::PH_LETTER && q_item.is_minus) begin
					minus_n = 1'b1;
					ph = gwp_pkg::PH_INT;
				end else if (q_item.is_digit) begin
					acc_n = (sh > (MB+5)'(CAP)) ? CAP : MB'(sh);
					ph = gwp_pkg::PH_INT;
				end else if (q_item.is_point && let_q != gwp_pkg::LT_G) begin
					ph = gwp_pkg::PH_FRAC;
					fc_n = 3'd0;
				end else begin
					fin_old = 1'b1;
					redisp = 1'b1;
				end
			end
			gwp_pkg::PH_FRAC: begin
				if (q_item.is_digit) begin
					if (fc_n < 3'(FRACTION_DIGITS)) begin
						acc_n = (fa > (MB+5)'(CAP)) ? CAP : MB'(fa);
						fc_n = fc_n + 3'd1;
					end
				end else begin
					fin_old = 1'b1;
					redisp = 1'b1;
				end
			end
			default: redisp = 1'b1;
		endcase
		idx_old = 3'(let_n - 3'd1);
		if (fin_old) begin
			if (let_n == gwp_pkg::LT_G) begin
				if (g_bad(minus_n, acc_n)) bad_n = 1'b1;
				else mot_n = acc_n[1:0];
			end else begin
				wv_n[idx_old] = word_val(minus_n, acc_n);
				seen_n[idx_old] = 1'b1;
			end
		end
		if (redisp) begin
			if (q_item.is_letter) begin
				ph = gwp_pkg::PH_LETTER;
				let_n = q_item.letter;
				minus_n = 1'b0;
				acc_n = '0;
				fc_n = 3'd0;
			end else ph = gwp_pkg::PH_IDLE;
		end
		// close the word still open at the end of the line
		idx_end = 3'(let_n - 3'd1);
		if (q_item.line_end && ph != gwp_pkg::PH_IDLE) begin
			if (let_n == gwp_pkg::LT_G) begin
				if (g_bad(minus_n, acc_n)) bad_n = 1'b1;
				else mot_n = acc_n[1:0];
			end else begin
				wv_n[idx_end] = word_val(minus_n, acc_n);
				seen_n[idx_end] = 1'b1;
			end
			ph = gwp_pkg::PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= gwp_pkg::PH_IDLE;
			let_q <= gwp_pkg::LT_G;
			minus_q <= 1'b0;
			acc_q <= '0;
			fc_q <= '0;
			mot_r_q <= '0;
			seen_r_q <= '0;
			bad_r_q <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 7; i++) wv_q[i] <= '0;
		end else begin
			if (take && q_item.line_end) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (take) begin
				ph_q <= ph;
				let_q <= let_n;
				minus_q <= minus_n;
				acc_q <= acc_n;
				fc_q <= fc_n;
				mot_r_q <= mot_n;
				seen_r_q <= seen_n;
				wv_q <= wv_n;
				bad_r_q <= q_item.line_end ? 1'b0 : bad_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && q_item.line_end) begin
			motion_q <= mot_n;
			val_q <= wv_n;
			seen_q <= seen_n;
			bad_q <= bad_n;
		end
	end
endmodule

FILE: rtl/gcode_word_parser.sv
// Top level of the G-code word parser.
// Depends on gwp_pkg, gwp_front, gwp_back.
// Takes one character per cycle; a four-entry queue parts the classifier from the
// word scanner, which also finishes one character per cycle, and a snapshot register
// holds each line result. Throughput is one character per cycle; the scanner stalls
// only while a snapshot waits on m_tready, and s_tready drops once the queue then
// holds four characters. A line-end character passes through the queue, and its snapshot
// is then loaded into the snapshot register.
module gcode_word_parser #(
	parameter int FRACTION_DIGITS = 4,
	parameter int VALUE_BITS = 40
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,  // character
	input  logic                       s_tuser,  // flush
	input  logic                       s_tlast,  // line_end
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// motion_mode, x, y, z, i, j, k, feed values, seen_mask, bad_motion
	output logic [7*VALUE_BITS+10+((8-((7*VALUE_BITS+10)%8))%8)-1:0] m_tdata
);
	localparam int W = 7 * VALUE_BITS + 10;
	localparam int WP = W + ((8 - (W % 8)) % 8);
	logic q_valid, q_ready;
	gwp_pkg::cls_t q_item;
	logic [1:0] mot;
	logic [VALUE_BITS-1:0] val [7];
	logic [6:0] seen;
	logic bad;
	logic [W-1:0] packed_d;

	gwp_front u_front (
		.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready), .in_char(s_tdata),
		.in_line_end(s_tlast), .in_flush(s_tuser),
		.q_valid, .q_ready, .q_item
	);
	gwp_back #(.FRACTION_DIGITS(FRACTION_DIGITS), .VALUE_BITS(VALUE_BITS)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_item, .out_valid(m_tvalid),
		.out_ready(m_tready), .motion_q(mot), .val_q(val), .seen_q(seen), .bad_q(bad)
	);

	assign packed_d = {bad, seen, val[6], val[5], val[4], val[3], val[2], val[1],
		val[0], mot};
	assign m_tdata = WP'(packed_d);
endmodule

FILE: rtl/gwp_checker.sv
// Port checker for the G-code word parser, bound to the top level.
// Depends on gcode_word_parser ports only.
module gwp_checker #(
	parameter int DW = 296
) (
	input logic          clk,
	input logic          arst_n,
	input logic          s_tready,
	input logic          m_tvalid,
	input logic          m_tready,
	input logic [DW-1:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("result changed while held");
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({s_tready, m_tvalid})) else $error("unknown handshake");
	a_rstv: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("valid after reset");
endmodule

bind gcode_word_parser gwp_checker #(.DW(WP)) u_chk (
	.clk, .arst_n, .s_tready, .m_tvalid, .m_tready, .m_tdata
);

FILE: test/tb_top.sv
// Testbench for gcode_word_parser: streams G-code text with random gaps and
// back-pressure, predicts each line snapshot and checks it field by field.
// Depends on gwp_pkg and the gcode_word_parser RTL.
`timescale 1ns / 1ps

module tb_top;
	localparam int FRAC = 4;
	localparam int VB = 40;
	localparam int OUT_W = 7*VB+10+((8-((7*VB+10)%8))%8);
	localparam int STALL_LIMIT = 20000;
	localparam int TAIL_CYCLES = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;  // character
	logic s_tuser = 1'b0;      // flush
	logic s_tlast = 1'b0;      // line_end
	logic m_tvalid;
	logic m_tready = 1'b0;
	// motion_mode, x, y, z, i, j, k, feed values, seen_mask, bad_motion
	logic [OUT_W-1:0] m_tdata;

	gcode_word_parser u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	typedef enum logic [1:0] {SC_IDLE, SC_LETTER, SC_INT, SC_FRAC} scan_t;

	logic [1:0] mdl_motion;
	logic [63:0] mdl_word [7];
	logic [6:0] mdl_seen;
	scan_t mdl_phase;
	gwp_pkg::letter_t mdl_letter;
	logic mdl_minus;
	logic [63:0] mdl_accum;
	int mdl_fcount;
	logic mdl_bad;

	logic [OUT_W-1:0] snap_q [$];
	int errors = 0;
	int stall_cycles = 0;
	bit idle_on = 1'b1;

	function automatic logic [63:0] pow10(int n);
		logic [63:0] p;
		p = 1;
		for (int i = 0; i < n; i++) p = p * 10;
		return p;
	endfunction

	function automatic logic [63:0] mag_cap();
		return 64'd1 << (VB - 1);
	endfunction

	function automatic void close_word();
		logic [63:0] v;
		int idx;
		if (mdl_letter == gwp_pkg::LT_G) begin
			if ((mdl_minus && mdl_accum != 0) || mdl_accum > 3) mdl_bad = 1'b1;
			else mdl_motion = mdl_accum[1:0];
		end else begin
			idx = int'(mdl_letter) - 1;
			if (mdl_minus) v = 64'd0 - mdl_accum;
			else v = (mdl_accum >= mag_cap()) ? mag_cap() - 1 : mdl_accum;
			mdl_word[idx] = v;
			mdl_seen[idx] = 1'b1;
		end
		mdl_phase = SC_IDLE;
	endfunction

	function automatic void start_word(logic [7:0] c);
		bit hit;
		hit = 1'b1;
		case (c)
			"G": mdl_letter = gwp_pkg::LT_G;
			"X": mdl_letter = gwp_pkg::LT_X;
			"Y": mdl_letter = gwp_pkg::LT_Y;
			"Z": mdl_letter = gwp_pkg::LT_Z;
			"I": mdl_letter = gwp_pkg::LT_I;
			"J": mdl_letter = gwp_pkg::LT_J;
			"K": mdl_letter = gwp_pkg::LT_K;
			"F": mdl_letter = gwp_pkg::LT_F;
			default: hit = 1'b0;
		endcase
		if (hit) begin
			mdl_phase = SC_LETTER;
			mdl_minus = 1'b0;
			mdl_accum = 0;
			mdl_fcount = 0;
		end
	endfunction

	function automatic void scan_char(logic [7:0] c);
		bit dig;
		logic [63:0] d, add, cap;
		bit is_g;
		dig = (c >= gwp_pkg::CH_ZERO && c <= gwp_pkg::CH_NINE);
		d = dig ? 64'(c - gwp_pkg::CH_ZERO) : 0;
		is_g = (mdl_letter == gwp_pkg::LT_G);
		cap = mag_cap();
		if (mdl_phase == SC_IDLE) begin
			start_word(c);
			return;
		end
		if (mdl_phase == SC_LETTER && c == gwp_pkg::CH_MINUS) begin
			mdl_minus = 1'b1;
			mdl_phase = SC_INT;
			return;
		end
		if (mdl_phase == SC_LETTER || mdl_phase == SC_INT) begin
			if (dig) begin
				add = d * (is_g ? 64'd1 : pow10(FRAC));
				if (add > cap || mdl_accum > (cap - add) / 10) mdl_accum = cap;
				else mdl_accum = mdl_accum * 10 + add;
				mdl_phase = SC_INT;
				return;
			end
			if (c == gwp_pkg::CH_POINT && !is_g) begin
				mdl_phase = SC_FRAC;
				mdl_fcount = 0;
				return;
			end
		end else if (dig) begin
			if (mdl_fcount < FRAC) begin
				add = d * pow10(FRAC - 1 - mdl_fcount);
				if (add > cap || mdl_accum > cap - add) mdl_accum = cap;
				else mdl_accum = mdl_accum + add;
				mdl_fcount++;
			end
			return;
		end
		close_word();
		start_word(c);
	endfunction

	function automatic void clear_words();
		mdl_motion = 0;
		for (int i = 0; i < 7; i++) mdl_word[i] = 0;
		mdl_seen = 0;
	endfunction

	function automatic void predict_line(logic [7:0] c, bit last, bit fl);
		logic [OUT_W-1:0] s;
		if (fl) begin
			clear_words();
			mdl_phase = SC_IDLE;
			mdl_minus = 0;
			mdl_accum = 0;
			mdl_fcount = 0;
		end
		scan_char(c);
		if (!last) return;
		if (mdl_phase != SC_IDLE) close_word();
		s = '0;
		s[1:0] = mdl_motion;
		for (int i = 0; i < 7; i++) s[2+i*VB +: VB] = mdl_word[i][VB-1:0];
		s[2+7*VB +: 7] = mdl_seen;
		s[9+7*VB] = mdl_bad;
		mdl_bad = 1'b0;
		snap_q = {snap_q, s};
	endfunction

	task automatic idle_gap();
		int n;
		if (!idle_on) return;
		n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 40);
		if (n != 0) s_tvalid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic send_char(logic [7:0] c, bit last, bit fl);
		idle_gap();
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= last;
		s_tuser <= fl;
		do @(posedge clk); while (!s_tready);
		predict_line(c, last, fl);
		@(negedge clk);
	endtask

	task automatic send_line(string txt, bit fl);
		for (int i = 0; i < txt.len(); i++)
			send_char(txt[i], i == txt.len() - 1, fl && i == 0);
	endtask

	always @(negedge clk) begin
		if (!idle_on) m_tready <= 1'b1;
		else if ($urandom_range(0, 19) == 0) m_tready <= 1'b0;
		else m_tready <= ($urandom_range(0, 3) != 0) || !m_tready;
	end

	always @(posedge clk) begin
		logic [OUT_W-1:0] e;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
		else stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (snap_q.size() == 0) begin
				$display("%0t snapshot exp none got %h", $realtime, m_tdata);
				errors++;
			end else begin
				e = snap_q.pop_front();
				if (e[1:0] !== m_tdata[1:0]) begin
					$display("%0t motion exp %0d got %0d", $realtime, e[1:0], m_tdata[1:0]);
					errors++;
				end
				for (int i = 0; i < 7; i++)
					if (e[2+i*VB +: VB] !== m_tdata[2+i*VB +: VB]) begin
						$display("%0t word %0d exp %h got %h", $realtime, i,
							e[2+i*VB +: VB], m_tdata[2+i*VB +: VB]);
						errors++;
					end
				if (e[2+7*VB +: 7] !== m_tdata[2+7*VB +: 7]) begin
					$display("%0t seen exp %b got %b", $realtime,
						e[2+7*VB +: 7], m_tdata[2+7*VB +: 7]);
					errors++;
				end
				if (e[9+7*VB] !== m_tdata[9+7*VB]) begin
					$display("%0t bad exp %b got %b", $realtime, e[9+7*VB], m_tdata[9+7*VB]);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		send_line("G0 X1.5 Y-2.25 Z0\n", 1'b0);
		send_line("G2I-.5J12.34567K.F100", 1'b0);
		send_line("G5X99999999999999Y-99999999999999", 1'b0);
		send_line("G-0G-1G3 x1 X Y- Z. I-.", 1'b0);
		send_line("X1.2.3Y1-2Z--3G1.5F7.0001", 1'b0);
		send_char(8'hFF, 1'b0, 1'b0);
		send_char(8'h00, 1'b0, 1'b0);
		send_char("\t", 1'b0, 1'b0);
		send_char("\r", 1'b1, 1'b0);
		send_line("X5", 1'b1);
		send_char("G", 1'b0, 1'b0);
		send_char("9", 1'b1, 1'b0);
		send_char(" ", 1'b1, 1'b0);
	endtask

	function automatic string rand_word();
		string w, letters;
		int nd;
		letters = "GXYZIJKF";
		w = "";
		w = {w, string'(letters[$urandom_range(0, 7)])};
		if ($urandom_range(0, 3) == 0) w = {w, "-"};
		nd = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 16) : $urandom_range(0, 4);
		for (int i = 0; i < nd; i++) w = {w, string'(8'("0") + 8'($urandom_range(0, 9)))};
		if ($urandom_range(0, 1)) begin
			w = {w, "."};
			nd = $urandom_range(0, 6);
			for (int i = 0; i < nd; i++)
				w = {w, string'(8'("0") + 8'($urandom_range(0, 9)))};
		end
		if ($urandom_range(0, 9) == 0) w = {w, string'(8'($urandom_range(0, 255)))};
		if ($urandom_range(0, 1)) w = {w, " "};
		return w;
	endfunction

	task automatic test_random(int items);
		int sent;
		string ln;
		bit fl;
		sent = 0;
		while (sent < items) begin
			ln = "";
			repeat ($urandom_range(1, 5)) ln = {ln, rand_word()};
			if ($urandom_range(0, 4) == 0) ln = {ln, string'(8'($urandom_range(0, 255)))};
			fl = ($urandom_range(0, 9) == 0);
			for (int i = 0; i < ln.len(); i++)
				send_char(ln[i], i == ln.len() - 1,
					(fl && i == 0) || ($urandom_range(0, 99) == 0));
			sent += ln.len();
			if ($urandom_range(0, 5) == 0) idle_on = !idle_on;
		end
		idle_on = 1'b1;
	endtask

	function automatic void ref_init();
		clear_words();
		mdl_phase = SC_IDLE;
		mdl_letter = gwp_pkg::LT_G;
		mdl_minus = 0;
		mdl_accum = 0;
		mdl_fcount = 0;
		mdl_bad = 0;
	endfunction

	initial begin
		ref_init();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(1900);
		s_tvalid <= 1'b0;
		while (snap_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end
endmodule

FILE: sim.f
rtl/gwp_pkg.sv
rtl/gwp_front.sv
rtl/gwp_back.sv
rtl/gcode_word_parser.sv
rtl/gwp_checker.sv
test/tb_top.sv
